// File: rtl/core/bfe_pkg.sv
// Shared types and constants of the 3x3 box filter.
package bfe_pkg;

  localparam int SIDE_W           = 11;
  localparam int CHAN_W           = 16;
  localparam int SIDE_RESET       = 1024;
  localparam int MAX_SIDE_DEF     = 1024;
  localparam int CHANNEL_BITS_DEF = 16;
  localparam int QUEUE_DEPTH      = 4;

  typedef logic [SIDE_W-1:0] side_t;

  typedef struct packed {
    logic              drain;
    logic [CHAN_W-1:0] red_in;
    logic [CHAN_W-1:0] green_in;
    logic [CHAN_W-1:0] blue_in;
  } pix_beat_t;

  typedef struct packed {
    logic [CHAN_W-1:0] red_out;
    logic [CHAN_W-1:0] green_out;
    logic [CHAN_W-1:0] blue_out;
    logic              frame_end;
  } res_beat_t;

  typedef struct packed {
    logic emit;
    logic row_top;
    logic row_bot;
    logic col_left;
    logic col_right;
    logic last;
  } flags_t;

  typedef enum logic [1:0] {
    DIV_9,
    DIV_6,
    DIV_4
  } div_e;

endpackage

// File: rtl/core/bfe_stream_if.sv
// Valid/ready channel carrying one payload beat.
interface bfe_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: rtl/core/box_filter_3x3_edge_average.sv
// 3x3 box filter top level: mean of the in-bounds neighborhood per channel.
//
// cfg_i carries the image side (clamped to 2..MAX_SIDE); writing it restarts the frame.
// Write it only while the block is idle. Reset sets the side to 1024 (or MAX_SIDE if
// smaller) and clears the raster counters; line store contents stay undefined.
// pix_i takes side*side pixel beats in raster order, then side+1 drain beats. A drain
// beat inside the pixels of a frame is dropped; a pixel beat during the drain phase
// counts as a drain beat. res_o gives one result per pixel in raster order, the last
// one of a frame with frame_end set.
// Throughput: one beat per cycle on both sides while res_o is not stalled. The result of a pixel is produced by
// the beat that arrives side+1 beats later and, once that beat is accepted, passes through
// the queue, line store read, column sums, total, reciprocal multiply and output register.
// When res_o stalls, the back pipeline holds and the front keeps taking beats until
// its 4-entry queue fills; pix_i.ready then drops until res_o moves again.
module box_filter_3x3_edge_average import bfe_pkg::*; #(
  parameter int MAX_SIDE     = MAX_SIDE_DEF,
  parameter int CHANNEL_BITS = CHANNEL_BITS_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  bfe_stream_if.sink    cfg_i,
  bfe_stream_if.sink    pix_i,
  bfe_stream_if.source  res_o
);

  localparam int ADDR_W = $clog2(MAX_SIDE);
  localparam int PIX_W  = 3 * CHANNEL_BITS;
  localparam int REC_W  = ADDR_W + PIX_W + $bits(flags_t);

  logic              push, full, pop, q_valid;
  logic [ADDR_W-1:0] f_addr;
  logic [PIX_W-1:0]  f_pix;
  flags_t            f_flags;
  logic [REC_W-1:0]  q_wdata, q_rdata;

  assign q_wdata = {f_addr, f_pix, f_flags};

  bfe_front #(
    .MAX_SIDE     (MAX_SIDE),
    .CHANNEL_BITS (CHANNEL_BITS)
  ) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg_i),
    .pix_i   (pix_i),
    .full_i  (full),
    .push_o  (push),
    .addr_o  (f_addr),
    .pix_o   (f_pix),
    .flags_o (f_flags)
  );

  bfe_queue #(
    .WIDTH (REC_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (q_wdata),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .data_o  (q_rdata)
  );

  bfe_back #(
    .MAX_SIDE     (MAX_SIDE),
    .CHANNEL_BITS (CHANNEL_BITS)
  ) u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (q_valid),
    .data_i  (q_rdata),
    .pop_o   (pop),
    .res_o   (res_o)
  );

endmodule

// File: rtl/core/bfe_front.sv
// Front end: side register, raster counters and per-beat classification.
module bfe_front import bfe_pkg::*; #(
  parameter int MAX_SIDE     = MAX_SIDE_DEF,
  parameter int CHANNEL_BITS = CHANNEL_BITS_DEF,
  localparam int ADDR_W      = $clog2(MAX_SIDE),
  localparam int PIX_W       = 3 * CHANNEL_BITS
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  bfe_stream_if.sink          cfg_i,
  bfe_stream_if.sink          pix_i,
  input  logic                full_i,
  output logic                push_o,
  output logic [ADDR_W-1:0]   addr_o,
  output logic [PIX_W-1:0]    pix_o,
  output flags_t              flags_o
);

  localparam int CNT_W = $clog2(MAX_SIDE + 2);
  localparam int DW    = (CNT_W > SIDE_W) ? CNT_W : SIDE_W;
  localparam int D_RST = (SIDE_RESET > MAX_SIDE) ? MAX_SIDE : SIDE_RESET;

  logic [CNT_W-1:0] d_q, d_d, row_q, row_d, col_q, col_d, drn_q, drn_d;
  logic [CNT_W-1:0] ir, ic, cr, cc, dm1, d_new;
  logic [DW-1:0]    side_ext;
  logic             pix_phase, take, skip, last_drain, ic_nz;

  assign cfg_i.ready = 1'b1;
  assign pix_i.ready = !full_i;

  always_comb begin
    side_ext = DW'(cfg_i.data);
    if (side_ext < DW'(2)) begin
      d_new = CNT_W'(2);
    end else if (side_ext > DW'(MAX_SIDE)) begin
      d_new = CNT_W'(MAX_SIDE);
    end else begin
      d_new = CNT_W'(side_ext);
    end
  end

  always_comb begin
    pix_phase  = row_q < d_q;
    take       = pix_i.valid && pix_i.ready;
    skip       = pix_phase && pix_i.data.drain;
    push_o     = take && !skip;
    last_drain = drn_q == d_q;
    dm1        = d_q - CNT_W'(1);
    if (pix_phase) begin
      ir = row_q;
      ic = col_q;
    end else if (last_drain) begin
      ir = d_q + CNT_W'(1);
      ic = '0;
    end else begin
      ir = d_q;
      ic = drn_q;
    end
    ic_nz = ic != '0;
    if (ic_nz) begin
      cr = ir - CNT_W'(1);
      cc = ic - CNT_W'(1);
      flags_o.emit = ir != '0;
    end else begin
      cr = ir - CNT_W'(2);
      cc = dm1;
      flags_o.emit = ir >= CNT_W'(2);
    end
    flags_o.row_top   = cr != '0;
    flags_o.row_bot   = cr != dm1;
    flags_o.col_left  = cc != '0;
    flags_o.col_right = cc != dm1;
    flags_o.last      = (cr == dm1) && (cc == dm1);
    addr_o = ADDR_W'(ic);
    if (pix_phase) begin
      pix_o = {pix_i.data.blue_in[CHANNEL_BITS-1:0], pix_i.data.green_in[CHANNEL_BITS-1:0],
               pix_i.data.red_in[CHANNEL_BITS-1:0]};
    end else begin
      pix_o = '0;
    end
  end

  always_comb begin
    d_d   = d_q;
    row_d = row_q;
    col_d = col_q;
    drn_d = drn_q;
    if (cfg_i.valid) begin
      d_d   = d_new;
      row_d = '0;
      col_d = '0;
      drn_d = '0;
    end else if (push_o) begin
      if (pix_phase) begin
        if (col_q == dm1) begin
          col_d = '0;
          row_d = row_q + CNT_W'(1);
        end else begin
          col_d = col_q + CNT_W'(1);
        end
      end else if (last_drain) begin
        row_d = '0;
        col_d = '0;
        drn_d = '0;
      end else begin
        drn_d = drn_q + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      d_q   <= CNT_W'(D_RST);
      row_q <= '0;
      col_q <= '0;
      drn_q <= '0;
    end else begin
      d_q   <= d_d;
      row_q <= row_d;
      col_q <= col_d;
      drn_q <= drn_d;
    end
  end

endmodule

// File: rtl/core/bfe_queue.sv
// Small register queue between the front and back ends.
module bfe_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             valid_o,
  output logic [WIDTH-1:0] data_o
);

  localparam int PW = $clog2(DEPTH);

  logic [WIDTH-1:0] slot_q [DEPTH];
  logic [PW:0]      wr_q, wr_d, rd_q, rd_d;

  assign full_o  = (wr_q[PW] != rd_q[PW]) && (wr_q[PW-1:0] == rd_q[PW-1:0]);
  assign valid_o = wr_q != rd_q;
  assign data_o  = slot_q[rd_q[PW-1:0]];

  always_comb begin
    wr_d = push_i ? wr_q + (PW+1)'(1) : wr_q;
    rd_d = pop_i  ? rd_q + (PW+1)'(1) : rd_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= '0;
      rd_q <= '0;
    end else begin
      wr_q <= wr_d;
      rd_q <= rd_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_q[PW-1:0]] <= data_i;
    end
  end

endmodule

// File: rtl/core/bfe_back.sv
// Back end: line store, 3x3 window, neighborhood sums and mean divide.
module bfe_back import bfe_pkg::*; #(
  parameter int MAX_SIDE     = MAX_SIDE_DEF,
  parameter int CHANNEL_BITS = CHANNEL_BITS_DEF,
  localparam int ADDR_W      = $clog2(MAX_SIDE),
  localparam int PIX_W       = 3 * CHANNEL_BITS,
  localparam int REC_W       = ADDR_W + PIX_W + $bits(flags_t)
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  input  logic [REC_W-1:0]   data_i,
  output logic               pop_o,
  bfe_stream_if.source       res_o
);

  localparam int CB    = CHANNEL_BITS;
  localparam int CS_W  = CB + 2;
  localparam int SUM_W = CB + 4;
  localparam int K     = SUM_W + 4;
  localparam int RW    = K - 1;
  localparam int PR_W  = SUM_W + RW;
  localparam int R9    = ((1 << K) + 8) / 9;
  localparam int R6    = ((1 << K) + 5) / 6;
  localparam int R4    = 1 << (K - 2);

  typedef logic [2:0][CB-1:0]   pix_t;
  typedef logic [2:0][2:0][CB-1:0] col_t;

  logic [2*PIX_W-1:0] mem [MAX_SIDE];

  logic [ADDR_W-1:0]  hd_addr;
  logic               en;

  logic               s1_v_q, fwd_q;
  logic [ADDR_W-1:0]  s1_addr_q;
  pix_t               s1_pix_q;
  flags_t             s1_flags_q;
  logic [2*PIX_W-1:0] rd_q, fwd_data_q, word, wr_word;
  col_t               prv1_q, prv2_q, ncol;
  col_t               cols [3];
  logic [2:0][2:0][CS_W-1:0] csum, csum_q;
  div_e               div, s2_div_q, s3_div_q;
  logic               s2_v_q, s2_last_q, s3_v_q, s3_last_q, s4_v_q, s4_last_q;
  logic [2:0][SUM_W-1:0] sum, s3_sum_q;
  logic [RW-1:0]      recip;
  logic [2:0][PR_W-1:0] prod, s4_prod_q;
  logic               out_valid_q, out_last_q;
  logic [2:0][CB-1:0] mean, out_mean_q;

  assign en      = !out_valid_q || res_o.ready;
  assign pop_o   = valid_i && en;
  assign hd_addr = data_i[REC_W-1 -: ADDR_W];

  always_comb begin
    word    = fwd_q ? fwd_data_q : rd_q;
    ncol[0] = pix_t'(word[2*PIX_W-1:PIX_W]);
    ncol[1] = pix_t'(word[PIX_W-1:0]);
    ncol[2] = s1_pix_q;
    wr_word = {word[PIX_W-1:0], PIX_W'(s1_pix_q)};
    cols[0] = prv2_q;
    cols[1] = prv1_q;
    cols[2] = ncol;
    for (int c = 0; c < 3; c++) begin
      for (int k = 0; k < 3; k++) begin
        csum[c][k] = (s1_flags_q.row_top ? CS_W'(cols[c][0][k]) : '0)
                   + CS_W'(cols[c][1][k])
                   + (s1_flags_q.row_bot ? CS_W'(cols[c][2][k]) : '0);
      end
    end
    if (!s1_flags_q.col_left) begin
      csum[0] = '0;
    end
    if (!s1_flags_q.col_right) begin
      csum[2] = '0;
    end
    if ((s1_flags_q.row_top && s1_flags_q.row_bot) &&
        (s1_flags_q.col_left && s1_flags_q.col_right)) begin
      div = DIV_9;
    end else if ((s1_flags_q.row_top && s1_flags_q.row_bot) ||
                 (s1_flags_q.col_left && s1_flags_q.col_right)) begin
      div = DIV_6;
    end else begin
      div = DIV_4;
    end
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      sum[k] = SUM_W'(csum_q[0][k]) + SUM_W'(csum_q[1][k]) + SUM_W'(csum_q[2][k]);
    end
    unique case (s3_div_q)
      DIV_9:   recip = RW'(R9);
      DIV_6:   recip = RW'(R6);
      DIV_4:   recip = RW'(R4);
      default: recip = RW'(R4);
    endcase
    for (int k = 0; k < 3; k++) begin
      prod[k] = PR_W'(s3_sum_q[k]) * PR_W'(recip);
      mean[k] = s4_prod_q[k][K +: CB];
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      rd_q <= mem[hd_addr];
    end
    if (en && s1_v_q) begin
      mem[s1_addr_q] <= wr_word;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q      <= 1'b0;
      fwd_q       <= 1'b0;
      s2_v_q      <= 1'b0;
      s3_v_q      <= 1'b0;
      s4_v_q      <= 1'b0;
      out_valid_q <= 1'b0;
      prv1_q      <= '0;
      prv2_q      <= '0;
    end else if (en) begin
      s1_v_q      <= pop_o;
      fwd_q       <= pop_o && s1_v_q && (s1_addr_q == hd_addr);
      s2_v_q      <= s1_v_q && s1_flags_q.emit;
      s3_v_q      <= s2_v_q;
      s4_v_q      <= s3_v_q;
      out_valid_q <= s4_v_q;
      if (s1_v_q) begin
        prv2_q <= prv1_q;
        prv1_q <= ncol;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      s1_addr_q  <= hd_addr;
      s1_pix_q   <= pix_t'(data_i[$bits(flags_t) +: PIX_W]);
      s1_flags_q <= flags_t'(data_i[$bits(flags_t)-1:0]);
      fwd_data_q <= wr_word;
    end
    if (en) begin
      csum_q     <= csum;
      s2_div_q   <= div;
      s2_last_q  <= s1_flags_q.last;
      s3_sum_q   <= sum;
      s3_div_q   <= s2_div_q;
      s3_last_q  <= s2_last_q;
      s4_prod_q  <= prod;
      s4_last_q  <= s3_last_q;
      out_mean_q <= mean;
      out_last_q <= s4_last_q;
    end
  end

  assign res_o.valid          = out_valid_q;
  assign res_o.data.red_out   = CHAN_W'(out_mean_q[0]);
  assign res_o.data.green_out = CHAN_W'(out_mean_q[1]);
  assign res_o.data.blue_out  = CHAN_W'(out_mean_q[2]);
  assign res_o.data.frame_end = out_last_q;

endmodule

// File: tb/box_filter_3x3_edge_average_tb.sv
// Testbench for the 3x3 box filter: random raster frames checked by a mean-filter scoreboard.
`timescale 1ns / 100ps

module box_filter_3x3_edge_average_tb;
  import bfe_pkg::*;

  localparam int STALL_LIMIT   = 4000;
  localparam int SETTLE_CYCLES = 20;
  localparam int RANDOM_ITEMS  = 600;

  typedef logic [2:0][CHAN_W-1:0] rgb_t;

  class blur_scoreboard;
    side_t       side_reg;
    rgb_t        line_mem [2*MAX_SIDE_DEF];
    rgb_t        win_col [6];
    int unsigned row_pos;
    int unsigned col_pos;
    int unsigned drain_cnt;
    res_beat_t   pending [$];
    int unsigned errors;

    function new();
      side_reg = side_t'(SIDE_RESET);
      foreach (line_mem[i]) line_mem[i] = '0;
      foreach (win_col[i]) win_col[i] = '0;
      row_pos   = 0;
      col_pos   = 0;
      drain_cnt = 0;
      errors    = 0;
    endfunction

    function void note_side(side_t v);
      side_reg  = v;
      row_pos   = 0;
      col_pos   = 0;
      drain_cnt = 0;
    endfunction

    function int unsigned side_eff();
      int unsigned d;
      d = 32'(side_reg);
      if (d < 2) d = 2;
      if (d > MAX_SIDE_DEF) d = MAX_SIDE_DEF;
      return d;
    endfunction

    function void note_beat(pix_beat_t b);
      int unsigned d, ir, ic, cr, cc, nr, nc, n, m;
      int unsigned sum [3];
      bit          ok_r [3];
      bit          ok_c [3];
      bit          emit;
      rgb_t        px, tap;
      rgb_t        ncol [3];
      div_e        mode;
      res_beat_t   want;
      d  = side_eff();
      px = '0;
      if (row_pos < d) begin
        if (b.drain) return;
        ir = row_pos;
        ic = col_pos;
        px = {b.blue_in, b.green_in, b.red_in};
      end else if (drain_cnt < d) begin
        ir = d;
        ic = drain_cnt;
      end else begin
        ir = d + 1;
        ic = 0;
      end
      if (ic >= d) ic = 0;

      ncol[0] = line_mem[MAX_SIDE_DEF + ic];
      ncol[1] = line_mem[ic];
      ncol[2] = px;
      line_mem[MAX_SIDE_DEF + ic] = ncol[1];
      line_mem[ic] = px;

      if (ic >= 1) begin
        emit = (ir >= 1);
        cr   = ir - 1;
        cc   = ic - 1;
      end else begin
        emit = (ir >= 2);
        cr   = ir - 2;
        cc   = d - 1;
      end

      if (emit) begin
        ok_r[0] = (cr >= 1);
        ok_r[1] = 1'b1;
        ok_r[2] = (cr + 2 <= d);
        ok_c[0] = (cc >= 1);
        ok_c[1] = 1'b1;
        ok_c[2] = (cc + 2 <= d);
        nr = 0;
        nc = 0;
        for (int i = 0; i < 3; i++) begin
          if (ok_r[i]) nr++;
          if (ok_c[i]) nc++;
          sum[i] = 0;
        end
        for (int r = 0; r < 3; r++) begin
          for (int c = 0; c < 3; c++) begin
            tap = (c == 0) ? win_col[3 + r] : (c == 1) ? win_col[r] : ncol[r];
            if (ok_r[r] && ok_c[c]) begin
              for (int k = 0; k < 3; k++) sum[k] += 32'(tap[k]);
            end
          end
        end
        n    = nr * nc;
        mode = (n == 9) ? DIV_9 : (n == 6) ? DIV_6 : DIV_4;
        for (int k = 0; k < 3; k++) begin
          case (mode)
            DIV_9:   m = sum[k] / 9;
            DIV_6:   m = sum[k] / 6;
            default: m = sum[k] >> 2;
          endcase
          px[k] = m[CHAN_W-1:0];
        end
        want.red_out   = px[0];
        want.green_out = px[1];
        want.blue_out  = px[2];
        want.frame_end = (cr == d - 1) && (cc == d - 1);
        pending.push_back(want);
      end

      win_col[3] = win_col[0];
      win_col[4] = win_col[1];
      win_col[5] = win_col[2];
      win_col[0] = ncol[0];
      win_col[1] = ncol[1];
      win_col[2] = ncol[2];

      if (row_pos < d) begin
        col_pos++;
        if (col_pos >= d) begin
          col_pos = 0;
          row_pos++;
        end
      end else begin
        drain_cnt++;
        if (drain_cnt > d) begin
          row_pos   = 0;
          col_pos   = 0;
          drain_cnt = 0;
        end
      end
    endfunction

    function void compare_field(string name, logic [CHAN_W-1:0] want, logic [CHAN_W-1:0] got);
      if (got !== want) begin
        $error("%s mismatch: expected %0d, actual %0d", name, want, got);
        errors++;
      end
    endfunction

    function void check_result(res_beat_t got);
      res_beat_t want;
      if (pending.size() == 0) begin
        $error("result beat with nothing pending: red_out %0d green_out %0d blue_out %0d",
               got.red_out, got.green_out, got.blue_out);
        errors++;
        return;
      end
      want = pending.pop_front();
      compare_field("red_out", want.red_out, got.red_out);
      compare_field("green_out", want.green_out, got.green_out);
      compare_field("blue_out", want.blue_out, got.blue_out);
      compare_field("frame_end", CHAN_W'(want.frame_end), CHAN_W'(got.frame_end));
    endfunction
  endclass

  logic clk;
  logic rst_n;

  bfe_stream_if #(.T(side_t))     cfg_if ();
  bfe_stream_if #(.T(pix_beat_t)) pix_if ();
  bfe_stream_if #(.T(res_beat_t)) res_if ();

  box_filter_3x3_edge_average u_top (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .cfg_i  (cfg_if),
    .pix_i  (pix_if),
    .res_o  (res_if)
  );

  blur_scoreboard sb;
  bit             tx_steady;
  bit             rx_steady;
  int unsigned    item_cnt;
  int unsigned    idle_cycles;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (res_if.valid && res_if.ready) sb.check_result(res_if.data);
      if (cfg_if.valid && cfg_if.ready) sb.note_side(cfg_if.data);
      if (pix_if.valid && pix_if.ready) sb.note_beat(pix_if.data);
      if ((res_if.valid && res_if.ready) || (cfg_if.valid && cfg_if.ready) ||
          (pix_if.valid && pix_if.ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= STALL_LIMIT) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  function automatic int gap_len(bit steady);
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [CHAN_W-1:0] rand_chan();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return CHAN_W'($urandom);
  endfunction

  task automatic send_pix(input logic drain, input logic [CHAN_W-1:0] r,
                          input logic [CHAN_W-1:0] g, input logic [CHAN_W-1:0] b);
    int n;
    n = gap_len(tx_steady);
    if (n > 0) begin
      pix_if.valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
    pix_if.valid <= 1'b1;
    pix_if.data  <= '{drain: drain, red_in: r, green_in: g, blue_in: b};
    do @(posedge clk); while (!pix_if.ready);
  endtask

  task automatic write_side(input side_t v);
    pix_if.valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.data  <= v;
    do @(posedge clk); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
  endtask

  // Pixels with stray drain beats, then the drain tail; stop after limit non-stray beats.
  task automatic run_frame(input int unsigned d, input int unsigned limit);
    int unsigned sent;
    sent = 0;
    for (int i = 0; i < d * d && sent < limit; i++) begin
      if ($urandom_range(0, 19) == 0) send_pix(1'b1, rand_chan(), rand_chan(), rand_chan());
      send_pix(1'b0, rand_chan(), rand_chan(), rand_chan());
      sent++;
    end
    for (int i = 0; i <= d && sent < limit; i++) begin
      send_pix($urandom_range(0, 4) != 0, rand_chan(), rand_chan(), rand_chan());
      sent++;
    end
    item_cnt += sent;
  endtask

  task automatic take_results();
    int n;
    forever begin
      n = gap_len(rx_steady);
      if (n > 0) begin
        res_if.ready <= 1'b0;
        repeat (n) @(posedge clk);
      end
      res_if.ready <= 1'b1;
      do @(posedge clk); while (!res_if.valid);
    end
  endtask

  initial begin
    int unsigned d;
    int unsigned frames;
    int unsigned phase;
    side_t       v;
    cfg_if.valid <= 1'b0;
    cfg_if.data  <= '0;
    pix_if.valid <= 1'b0;
    pix_if.data  <= '0;
    res_if.ready <= 1'b0;
    rst_n        <= 1'b0;
    tx_steady    = 1'b0;
    rx_steady    = 1'b0;
    item_cnt     = 0;
    idle_cycles  = 0;
    sb           = new();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    fork
      take_results();
    join_none

    // reset side: a stretch of the first row, no result due yet
    run_frame(SIDE_RESET, $urandom_range(40, 80));

    // smallest frame: corners only, stray drain, pixel inside the drain tail
    write_side(side_t'(2));
    send_pix(1'b0, '1, '1, '1);
    send_pix(1'b1, 16'h1234, 16'h5678, 16'h9abc);
    send_pix(1'b0, '0, '0, '0);
    send_pix(1'b0, '1, '0, '1);
    send_pix(1'b0, '0, '1, 16'h8000);
    send_pix(1'b1, '0, '0, '0);
    send_pix(1'b0, 16'haaaa, 16'h5555, '1);
    send_pix(1'b1, '1, '1, '1);

    // all-max 3x3: full sums on every divisor
    write_side(side_t'(3));
    for (int i = 0; i < 9; i++) send_pix(1'b0, '1, '1, '1);
    for (int i = 0; i < 4; i++) send_pix(1'b1, '0, '0, '0);

    phase = 0;
    while (item_cnt < RANDOM_ITEMS) begin
      case (phase)
        0:       v = side_t'(0);
        1:       v = side_t'(1);
        default: v = ($urandom_range(0, 4) == 0) ? side_t'($urandom_range(9, 16))
                                                 : side_t'($urandom_range(2, 8));
      endcase
      phase++;
      tx_steady = ($urandom_range(0, 3) == 0);
      rx_steady = ($urandom_range(0, 3) == 0);
      write_side(v);
      d      = sb.side_eff();
      frames = $urandom_range(1, 3);
      for (int f = 0; f < frames; f++) begin
        if (item_cnt >= RANDOM_ITEMS) break;
        if ($urandom_range(0, 7) == 0) begin
          run_frame(d, $urandom_range(1, d * d + d));
          break;
        end
        run_frame(d, d * d + d + 1);
      end
    end

    tx_steady = 1'b0;
    rx_steady = 1'b0;
    write_side(side_t'(2047));
    run_frame(MAX_SIDE_DEF, $urandom_range(20, 40));

    pix_if.valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
